[src/itbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package itbd_pkg;

   localparam int MAX_SYMBOLS    = 16;
   localparam int VALUE_BITS     = 32;
   localparam int SYMBOL_BITS    = 8;
   localparam int DIGIT_BITS     = $clog2(MAX_SYMBOLS);
   localparam int SIZE_BITS      = 5;
   localparam int STORE_DEPTH    = 32;
   localparam int STORE_IDX_BITS = $clog2(STORE_DEPTH);
   localparam int COUNT_BITS     = STORE_IDX_BITS + 1;
   localparam int SYMS_BITS      = MAX_SYMBOLS * SYMBOL_BITS;
   localparam int REG_BITS       = 64;
   localparam int ADDR_BITS      = 5;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;
   localparam int BYTE_STEPS     = VALUE_BITS / 8;
   localparam int STEP_BITS      = $clog2(BYTE_STEPS);

   localparam logic [SYMBOL_BITS-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYMBOL_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [SYMBOL_BITS-1:0] CHAR_NONE  = 8'h00;

   localparam logic [1:0] REG_BASE_SIZE    = 2'd0;
   localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
   localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

   localparam logic [SIZE_BITS-1:0] BASE_SIZE_RESET    = 5'd10;
   localparam logic [REG_BITS-1:0]  SYMBOLS_LOW_RESET  = 64'h3736353433323130;
   localparam logic [REG_BITS-1:0]  SYMBOLS_HIGH_RESET = 64'h4645444342413938;

   typedef struct packed {
      logic [SIZE_BITS-1:0] base_size;
      logic [REG_BITS-1:0]  symbols_low;
      logic [REG_BITS-1:0]  symbols_high;
   } cfg_type;

   typedef struct packed {
      logic                  err;
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
   } item_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_ERROR,
      BACK_DIVIDE,
      BACK_SIGN,
      BACK_DIGITS
   } back_state_type;

   function automatic logic [SYMBOL_BITS-1:0] symbol_at(input logic [SYMS_BITS-1:0] syms,
                                                        input logic [DIGIT_BITS-1:0] k);
      return syms[SYMBOL_BITS*k +: SYMBOL_BITS];
   endfunction

   // Radix in range, no sign characters, no repeated symbol among those in use.
   function automatic logic base_ok(input logic [SIZE_BITS-1:0] size,
                                    input logic [SYMS_BITS-1:0] syms);
      logic ok;
      logic [SYMBOL_BITS-1:0] sa;
      ok = (size >= SIZE_BITS'(2)) && (size <= SIZE_BITS'(MAX_SYMBOLS));
      for (int a = 0; a < MAX_SYMBOLS; a++) begin
         sa = syms[SYMBOL_BITS*a +: SYMBOL_BITS];
         if (SIZE_BITS'(a) < size) begin
            if (sa inside {CHAR_PLUS, CHAR_MINUS}) ok = 1'b0;
            for (int b = a + 1; b < MAX_SYMBOLS; b++) begin
               if ((SIZE_BITS'(b) < size) && (syms[SYMBOL_BITS*b +: SYMBOL_BITS] == sa))
                  ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

endpackage
`default_nettype wire

[src/itbd_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
module itbd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [itbd_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire logic [itbd_pkg::REG_BITS-1:0]  csr_pwdata,
   output      logic [itbd_pkg::REG_BITS-1:0]  csr_prdata,
   output      logic                           csr_pready,
   output      itbd_pkg::cfg_type              cfg
);

   itbd_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [1:0]        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[4:3];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            itbd_pkg::REG_BASE_SIZE:    cfg_in.base_size    = csr_pwdata[itbd_pkg::SIZE_BITS-1:0];
            itbd_pkg::REG_SYMBOLS_LOW:  cfg_in.symbols_low  = csr_pwdata;
            itbd_pkg::REG_SYMBOLS_HIGH: cfg_in.symbols_high = csr_pwdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         itbd_pkg::REG_BASE_SIZE:
            csr_prdata = itbd_pkg::REG_BITS'(cfg_ff.base_size);
         itbd_pkg::REG_SYMBOLS_LOW:  csr_prdata = cfg_ff.symbols_low;
         itbd_pkg::REG_SYMBOLS_HIGH: csr_prdata = cfg_ff.symbols_high;
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_size    <= itbd_pkg::BASE_SIZE_RESET;
         cfg_ff.symbols_low  <= itbd_pkg::SYMBOLS_LOW_RESET;
         cfg_ff.symbols_high <= itbd_pkg::SYMBOLS_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[src/itbd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module itbd_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [itbd_pkg::VALUE_BITS-1:0] req_tdata,
   input  wire itbd_pkg::cfg_type               cfg,
   output      logic                            push_valid,
   input  wire logic                            push_ready,
   output      itbd_pkg::item_type              push_item
);

   logic               valid_ff, valid_in;
   itbd_pkg::item_type item_ff, item_in;
   logic               take;
   logic               neg;

   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   // Magnitude of the most negative value wraps to exactly 2^(n-1) as unsigned.
   assign neg = req_tdata[itbd_pkg::VALUE_BITS-1];

   always_comb begin
      item_in     = item_ff;
      if (take) begin
         item_in.neg = neg;
         item_in.mag = neg ? (~req_tdata + itbd_pkg::VALUE_BITS'(1)) : req_tdata;
         item_in.err = !itbd_pkg::base_ok(cfg.base_size,
                                          {cfg.symbols_high, cfg.symbols_low});
      end
   end

   always_comb begin
      if (take) valid_in = 1'b1;
      else if (push_ready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule
`default_nettype wire

[src/itbd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module itbd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output      logic               push_ready,
   input  wire itbd_pkg::item_type push_item,
   output      logic               pop_valid,
   input  wire logic               pop,
   output      itbd_pkg::item_type pop_item
);

   itbd_pkg::item_type                   slot [itbd_pkg::QUEUE_DEPTH];
   logic [itbd_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [itbd_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [itbd_pkg::QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic                                 do_push, do_pop;

   assign push_ready = count_ff != itbd_pkg::QUEUE_CNT_BITS'(itbd_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = slot[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + itbd_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + itbd_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + itbd_pkg::QUEUE_CNT_BITS'(1);
      else if (do_pop && !do_push) count_in = count_ff - itbd_pkg::QUEUE_CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

[src/itbd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module itbd_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire itbd_pkg::cfg_type                cfg,
   input  wire logic                             pop_valid,
   output      logic                             pop,
   input  wire itbd_pkg::item_type               pop_item,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [itbd_pkg::SYMBOL_BITS-1:0] rsp_tdata,
   output      logic                             rsp_tlast,
   output      logic                             rsp_tuser
);

   itbd_pkg::back_state_type state_ff, state_in;

   logic [itbd_pkg::VALUE_BITS-1:0]     work_ff, work_in;
   logic [itbd_pkg::DIGIT_BITS-1:0]     rem_ff, rem_in;
   logic [itbd_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic [itbd_pkg::COUNT_BITS-1:0]     count_ff, count_in;
   logic [itbd_pkg::STORE_IDX_BITS-1:0] idx_ff, idx_in;
   logic                                neg_ff, neg_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [itbd_pkg::SYMBOL_BITS-1:0]    rsp_char_ff, rsp_char_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                rsp_err_ff, rsp_err_in;

   logic [itbd_pkg::DIGIT_BITS-1:0]     digit_mem [itbd_pkg::STORE_DEPTH];
   logic                                mem_we;
   logic [itbd_pkg::DIGIT_BITS-1:0]     mem_rd_ff;

   logic                                out_free;
   logic                                last_step;
   logic                                div_done;
   logic [itbd_pkg::DIGIT_BITS:0]       part;
   logic [itbd_pkg::DIGIT_BITS-1:0]     div_rem;
   logic [7:0]                          qbyte;
   logic [itbd_pkg::VALUE_BITS-1:0]     div_work;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   // One byte of long division by the radix: eight restoring steps on a 5-bit partial remainder.
   always_comb begin
      part = '0;
      qbyte = '0;
      div_rem = rem_ff;
      for (int i = 0; i < 8; i++) begin
         part = {div_rem, work_ff[itbd_pkg::VALUE_BITS-1-i]};
         if (part >= cfg.base_size) begin
            qbyte[7-i] = 1'b1;
            part = part - cfg.base_size;
         end
         div_rem = part[itbd_pkg::DIGIT_BITS-1:0];
      end
      div_work = {work_ff[itbd_pkg::VALUE_BITS-9:0], qbyte};
   end

   assign last_step = step_ff == itbd_pkg::STEP_BITS'(itbd_pkg::BYTE_STEPS - 1);
   assign div_done  = (div_work == '0) ||
                      (count_ff == itbd_pkg::COUNT_BITS'(itbd_pkg::STORE_DEPTH - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itbd_pkg::BACK_IDLE:
            if (pop_valid)
               state_in = pop_item.err ? itbd_pkg::BACK_ERROR : itbd_pkg::BACK_DIVIDE;
         itbd_pkg::BACK_ERROR:
            if (out_free) state_in = itbd_pkg::BACK_IDLE;
         itbd_pkg::BACK_DIVIDE:
            if (last_step && div_done)
               state_in = neg_ff ? itbd_pkg::BACK_SIGN : itbd_pkg::BACK_DIGITS;
         itbd_pkg::BACK_SIGN:
            if (out_free) state_in = itbd_pkg::BACK_DIGITS;
         itbd_pkg::BACK_DIGITS:
            if (out_free && (idx_ff == '0)) state_in = itbd_pkg::BACK_IDLE;
         default:
            state_in = itbd_pkg::BACK_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      pop          = 1'b0;
      mem_we       = 1'b0;
      work_in      = work_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         itbd_pkg::BACK_IDLE: begin
            pop      = pop_valid;
            work_in  = pop_item.mag;
            neg_in   = pop_item.neg;
            rem_in   = '0;
            step_in  = '0;
            count_in = '0;
         end
         itbd_pkg::BACK_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itbd_pkg::CHAR_NONE;
               rsp_last_in  = 1'b1;
               rsp_err_in   = 1'b1;
            end
         end
         itbd_pkg::BACK_DIVIDE: begin
            work_in = div_work;
            rem_in  = div_rem;
            step_in = step_ff + itbd_pkg::STEP_BITS'(1);
            if (last_step) begin
               mem_we   = 1'b1;
               rem_in   = '0;
               count_in = count_ff + itbd_pkg::COUNT_BITS'(1);
               idx_in   = count_ff[itbd_pkg::STORE_IDX_BITS-1:0];
            end
         end
         itbd_pkg::BACK_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itbd_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_err_in   = 1'b0;
            end
         end
         itbd_pkg::BACK_DIGITS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itbd_pkg::symbol_at({cfg.symbols_high, cfg.symbols_low}, mem_rd_ff);
               rsp_last_in  = idx_ff == '0;
               rsp_err_in   = 1'b0;
               idx_in       = idx_ff - itbd_pkg::STORE_IDX_BITS'(1);
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itbd_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // Read at the next index; forward the digit being written, which is always
   // the one the next index points at.
   always_ff @(posedge clock) begin
      if (mem_we) digit_mem[count_ff[itbd_pkg::STORE_IDX_BITS-1:0]] <= div_rem;
      mem_rd_ff <= mem_we ? div_rem : digit_mem[idx_in];
   end

endmodule
`default_nettype wire

[src/integer_to_base_digits.sv]
`timescale 1ns / 1ps
`default_nettype none
// Converts a signed 32-bit value to its text in a configurable base.
// req_*: one transfer carries one value (two's complement) in req_tdata.
// rsp_*: one transfer per character: a leading '-' for negatives, then the
//   digits from most significant down; rsp_tlast marks the final character.
//   If the symbol set is invalid (radix below 2 or above 16, a repeated symbol,
//   or a '+' / '-' among the symbols in use) a single transfer with
//   rsp_tuser = 1, rsp_tdata = 0 and rsp_tlast = 1 is sent instead.
// csr_*: registers base_size (0x00), symbols_low (0x08), symbols_high (0x10);
//   write only while the block is idle.
// Flow: a value is registered in the input stage, then waits in a
//   two-entry queue. The back end divides by the radix one byte of the
//   magnitude per cycle, storing one digit per pass over the whole value, then
//   emits the stored digits as characters. The back end takes a new value
//   only once it has issued the last character of the one before.
//   The input keeps accepting while the queue has room.
// Reset clears the input stage, the queue and the back end; registers return
//   to base 10 with symbols "0123456789ABCDEF".
// When the receiver stalls, the current character holds on rsp_* and the back
//   end waits; the queue and input stage fill, then req_tready drops.
module integer_to_base_digits (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [7:0] character
   output      logic        rsp_tlast,
   output      logic        rsp_tuser,   // [0] error
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output      logic [63:0] csr_prdata,
   output      logic        csr_pready
);

   itbd_pkg::cfg_type  cfg;
   logic               push_valid;
   logic               push_ready;
   itbd_pkg::item_type push_item;
   logic               pop_valid;
   logic               pop;
   itbd_pkg::item_type pop_item;

   // Register file
   itbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Accept a value, take its sign and magnitude, flag a bad symbol set
   itbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Hold classified values until the back end is free
   itbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   // Divide into digits, store them, then emit characters most significant first
   itbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

[src/itbd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module itbd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   // No character may be pending right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("output valid right after reset");

   // A stalled character holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled output changed");

   // An error result stands alone and carries no character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == 8'h00))
      else $error("error result not sole or not zero");

   // A minus sign is always followed by at least one digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && (rsp_tdata == 8'h2D) |-> !rsp_tlast)
      else $error("sign emitted as final character");

endmodule

bind integer_to_base_digits itbd_checker u_itbd_checker (.*);
`default_nettype wire
